[design/warp_grid_bilinear_coordinate_generator_assert.svh]
// ----------------------------------------------------------------------------
// Warp grid coordinate generator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WARP_GRID_BILINEAR_COORDINATE_GENERATOR_ASSERT_SVH
`define WARP_GRID_BILINEAR_COORDINATE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define WGBC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wgbc: same-cycle check failed");

// next-cycle implication
`define WGBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wgbc: next-cycle check failed");

`endif

[design/wgbc_pkg.sv]
// ----------------------------------------------------------------------------
// Warp grid coordinate generator package
// Shared widths, codes and the tap control word of the blend pipeline.
// ----------------------------------------------------------------------------
package wgbc_pkg;

   localparam int GRID_COLS_DEF  = 64;
   localparam int GRID_ROWS_DEF  = 64;
   localparam int VALUE_BITS_DEF = 32;

   localparam int OP_BITS        = 2;
   localparam int NODE_IDX_BITS  = 6;
   localparam int NODE_BITS      = 32;
   localparam int COORD_BITS     = 16;
   localparam int OUT_BITS       = 32;
   localparam int POS_BITS       = 17;
   localparam int STEP_BITS      = 3;
   localparam int FRAC_BITS      = 7;
   localparam int SPAN_BITS      = 8;
   localparam int WEIGHT_BITS    = 15;
   localparam int SHIFT_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [OP_BITS-1:0] OP_WRITE_NODE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_START_LINE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ADVANCE    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_LOG2 = 2'd2;

   localparam logic [STEP_BITS-1:0] STEP_LOG2_RESET = 3'd4;

   typedef struct packed {
      logic                   valid;
      logic                   first;
      logic                   last;
      logic [WEIGHT_BITS-1:0] weight;
   } tap_ctl_type;

endpackage

[design/wgbc_node_ram.sv]
// ----------------------------------------------------------------------------
// Node memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wgbc_node_ram #(
   parameter int DEPTH     = 4096,
   parameter int WIDTH     = 64,
   parameter int ADDR_BITS = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/wgbc_blend.sv]
// ----------------------------------------------------------------------------
// Bilinear blend pipeline
// Weights one node pair per tap, accumulates four taps, floors by 2^(2s).
// ----------------------------------------------------------------------------
module wgbc_blend #(
   parameter int VALUE_BITS = wgbc_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wgbc_pkg::tap_ctl_type                 tap_ctl,
   input  logic signed [VALUE_BITS-1:0]          node_x,
   input  logic signed [VALUE_BITS-1:0]          node_y,
   input  logic [wgbc_pkg::SHIFT_BITS-1:0]       shift,
   output logic                                  res_valid,
   output logic signed [wgbc_pkg::OUT_BITS-1:0]  res_x,
   output logic signed [wgbc_pkg::OUT_BITS-1:0]  res_y
);
   import wgbc_pkg::*;

   localparam int ACC_BITS = VALUE_BITS + WEIGHT_BITS + 1;

   tap_ctl_type                tap_ff;
   logic signed [WEIGHT_BITS:0] weight_s;
   logic signed [ACC_BITS-1:0]  prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic                        prod_valid_ff, prod_first_ff, prod_last_ff;
   logic signed [ACC_BITS-1:0]  acc_x_in, acc_y_in, acc_x_ff, acc_y_ff;
   logic                        acc_done_ff;
   logic signed [ACC_BITS-1:0]  shift_x, shift_y;
   logic signed [OUT_BITS-1:0]  res_x_ff, res_y_ff;
   logic                        res_valid_ff;

   // align the tap word with the registered memory data
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_ctl;
      end
   end

   assign weight_s  = signed'({1'b0, tap_ff.weight});
   assign prod_x_in = node_x * weight_s;
   assign prod_y_in = node_y * weight_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= tap_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tap_ff.valid) begin
         prod_x_ff     <= prod_x_in;
         prod_y_ff     <= prod_y_in;
         prod_first_ff <= tap_ff.first;
         prod_last_ff  <= tap_ff.last;
      end
   end

   assign acc_x_in = prod_first_ff ? prod_x_ff : acc_x_ff + prod_x_ff;
   assign acc_y_in = prod_first_ff ? prod_y_ff : acc_y_ff + prod_y_ff;

   always_ff @(posedge clock) begin
      if (prod_valid_ff) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_done_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         acc_done_ff  <= prod_valid_ff && prod_last_ff;
         res_valid_ff <= acc_done_ff;
      end
   end

   // arithmetic shift floors toward minus infinity
   assign shift_x = acc_x_ff >>> shift;
   assign shift_y = acc_y_ff >>> shift;

   always_ff @(posedge clock) begin
      if (acc_done_ff) begin
         res_x_ff <= shift_x[OUT_BITS-1:0];
         res_y_ff <= shift_y[OUT_BITS-1:0];
      end
   end

   assign res_valid = res_valid_ff;
   assign res_x     = res_x_ff;
   assign res_y     = res_y_ff;

endmodule

[design/warp_grid_bilinear_coordinate_generator.sv]
// ----------------------------------------------------------------------------
// Warp grid bilinear coordinate generator
// Two node grids in one memory; per pixel four reads feed a multiply-accumulate
// pipeline that blends the source X and Y coordinates.
// ----------------------------------------------------------------------------
// Sequence: an in-grid pixel passes CALC, four READ steps and WAIT to DONE;
//   an out-of-range pixel goes from CALC to DONE. Node writes and idle
//   operations leave the block in IDLE. A new pixel is taken only in IDLE,
//   so pixels never overlap in the node memory read port or blend pipeline.
// Reset: clears control, position and origin; step_log2 goes to 4; memory not cleared.
// ----------------------------------------------------------------------------
`include "warp_grid_bilinear_coordinate_generator_assert.svh"

module warp_grid_bilinear_coordinate_generator #(
   parameter int GRID_COLS  = wgbc_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS  = wgbc_pkg::GRID_ROWS_DEF,
   parameter int VALUE_BITS = wgbc_pkg::VALUE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [wgbc_pkg::OP_BITS-1:0]            req_operation,
   input  logic [wgbc_pkg::NODE_IDX_BITS-1:0]      req_node_col,
   input  logic [wgbc_pkg::NODE_IDX_BITS-1:0]      req_node_row,
   input  logic signed [wgbc_pkg::NODE_BITS-1:0]   req_node_map_x,
   input  logic signed [wgbc_pkg::NODE_BITS-1:0]   req_node_map_y,
   input  logic [wgbc_pkg::COORD_BITS-1:0]         req_pos_x,
   input  logic [wgbc_pkg::COORD_BITS-1:0]         req_pos_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [wgbc_pkg::OUT_BITS-1:0]    rsp_map_x,
   output logic signed [wgbc_pkg::OUT_BITS-1:0]    rsp_map_y,
   output logic                                    rsp_out_of_range,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [wgbc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wgbc_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import wgbc_pkg::*;

   localparam int NODE_COUNT = GRID_COLS * GRID_ROWS;
   localparam int ADDR_BITS  = $clog2(NODE_COUNT);
   localparam int WORD_BITS  = 2 * VALUE_BITS;
   localparam int EXT_BITS   = 64;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CALC = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [COORD_BITS-1:0]     origin_x_ff, origin_y_ff;
   logic [STEP_BITS-1:0]      step_ff;
   logic [POS_BITS-1:0]       cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic [ADDR_BITS-1:0]      base_ff, base_in;
   logic [WEIGHT_BITS-1:0]    w00_ff, w01_ff, w10_ff, w11_ff;
   logic [WEIGHT_BITS-1:0]    w00_in, w01_in, w10_in, w11_in;
   logic                      oor_ff, oor_in;
   logic [1:0]                tap_ff, tap_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0] rsp_map_x_ff, rsp_map_y_ff;
   logic                      rsp_oor_ff;

   logic                      req_fire, rsp_load;
   logic                      node_wr_en;
   logic [ADDR_BITS-1:0]      node_wr_addr, rd_addr;
   logic [WORD_BITS-1:0]      node_wr_data, rd_data;
   logic signed [EXT_BITS-1:0] node_x_ext, node_y_ext;

   logic [COORD_BITS-1:0]     xo, yo;
   logic [SPAN_BITS-1:0]      span, px0, py0;
   logic [FRAC_BITS-1:0]      frac_mask, px1, py1;
   logic [ADDR_BITS-1:0]      tap_offset;
   logic [WEIGHT_BITS-1:0]    tap_weight;
   tap_ctl_type               tap_ctl;
   logic                      blend_done;
   logic signed [OUT_BITS-1:0] blend_x, blend_y;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         step_ff     <= STEP_LOG2_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:  origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y:  origin_y_ff <= csr_wdata;
            CSR_STEP_LOG2: step_ff     <= csr_wdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---- node writes ----
   assign node_x_ext   = EXT_BITS'(req_node_map_x);
   assign node_y_ext   = EXT_BITS'(req_node_map_y);
   assign node_wr_data = {node_y_ext[VALUE_BITS-1:0], node_x_ext[VALUE_BITS-1:0]};
   assign node_wr_addr = ADDR_BITS'(req_node_row) * ADDR_BITS'(GRID_COLS)
                       + ADDR_BITS'(req_node_col);
   // drop writes outside the grid
   assign node_wr_en   = req_fire && (req_operation == OP_WRITE_NODE)
                       && (32'(req_node_col) < GRID_COLS)
                       && (32'(req_node_row) < GRID_ROWS);

   // ---- position ----
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (req_fire && (req_operation == OP_START_LINE)) begin
         cur_col_in = POS_BITS'(req_pos_x) - POS_BITS'(origin_x_ff);
         cur_row_in = POS_BITS'(req_pos_y) - POS_BITS'(origin_y_ff);
      end else if (req_fire && (req_operation == OP_ADVANCE)) begin
         cur_col_in = cur_col_ff + POS_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

   // ---- cell lookup: node indices, weights, base address ----
   assign xo        = cur_col_ff[COORD_BITS-1:0] >> step_ff;
   assign yo        = cur_row_ff[COORD_BITS-1:0] >> step_ff;
   assign span      = SPAN_BITS'(1) << step_ff;
   assign frac_mask = FRAC_BITS'(span - SPAN_BITS'(1));
   assign px1       = cur_col_ff[FRAC_BITS-1:0] & frac_mask;
   assign py1       = cur_row_ff[FRAC_BITS-1:0] & frac_mask;
   assign px0       = span - SPAN_BITS'(px1);
   assign py0       = span - SPAN_BITS'(py1);

   assign w00_in  = WEIGHT_BITS'(16'(px0) * 16'(py0));
   assign w01_in  = WEIGHT_BITS'(16'(px1) * 16'(py0));
   assign w10_in  = WEIGHT_BITS'(16'(px0) * 16'(py1));
   assign w11_in  = WEIGHT_BITS'(16'(px1) * 16'(py1));
   assign base_in = ADDR_BITS'(yo) * ADDR_BITS'(GRID_COLS) + ADDR_BITS'(xo);
   // the cell needs the next node column and row as well
   assign oor_in  = cur_col_ff[POS_BITS-1] || cur_row_ff[POS_BITS-1]
                 || (32'(xo) >= GRID_COLS - 1) || (32'(yo) >= GRID_ROWS - 1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         base_ff <= base_in;
         w00_ff  <= w00_in;
         w01_ff  <= w01_in;
         w10_ff  <= w10_in;
         w11_ff  <= w11_in;
         oor_ff  <= oor_in;
      end
   end

   // ---- tap sequencer ----
   always_comb begin
      case (tap_ff)
         2'd0:    begin tap_offset = '0;                                  tap_weight = w00_ff; end
         2'd1:    begin tap_offset = ADDR_BITS'(1);                       tap_weight = w01_ff; end
         2'd2:    begin tap_offset = ADDR_BITS'(GRID_COLS);               tap_weight = w10_ff; end
         default: begin tap_offset = ADDR_BITS'(GRID_COLS) + ADDR_BITS'(1); tap_weight = w11_ff; end
      endcase
   end

   assign rd_addr        = base_ff + tap_offset;
   assign tap_ctl.valid  = (state_ff == ST_READ);
   assign tap_ctl.first  = (tap_ff == 2'd0);
   assign tap_ctl.last   = (tap_ff == 2'd3);
   assign tap_ctl.weight = tap_weight;

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && ((req_operation == OP_START_LINE)
                             || (req_operation == OP_ADVANCE))) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            tap_in   = 2'd0;
            state_in = oor_in ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            tap_in = tap_ff + 2'd1;
            if (tap_ff == 2'd3) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (blend_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   // ---- output register ----
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_map_x_ff <= oor_ff ? '0 : blend_x;
         rsp_map_y_ff <= oor_ff ? '0 : blend_y;
         rsp_oor_ff   <= oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_map_x        = rsp_map_x_ff;
   assign rsp_map_y        = rsp_map_y_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // ---- datapath ----
   wgbc_node_ram #(
      .DEPTH     (NODE_COUNT),
      .WIDTH     (WORD_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   (tap_ctl.valid),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wgbc_blend #(
      .VALUE_BITS (VALUE_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .tap_ctl   (tap_ctl),
      .node_x    (signed'(rd_data[VALUE_BITS-1:0])),
      .node_y    (signed'(rd_data[WORD_BITS-1:VALUE_BITS])),
      .shift     ({step_ff, 1'b0}),
      .res_valid (blend_done),
      .res_x     (blend_x),
      .res_y     (blend_y)
   );

   // ---- checks ----
   `WGBC_ASSERT_IMPLY(a_oor_gives_zero, clock, reset, rsp_valid && rsp_out_of_range, (rsp_map_x == '0) && (rsp_map_y == '0))
   `WGBC_ASSERT_IMPLY(a_blend_done_in_wait, clock, reset, blend_done, state_ff == ST_WAIT)
   `WGBC_ASSERT_NEXT(a_pixel_enters_calc, clock, reset, req_fire && ((req_operation == OP_START_LINE) || (req_operation == OP_ADVANCE)), state_ff == ST_CALC)

endmodule

[verif/warp_coord_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warp grid coordinate checker
// Watches the request, result and register channels of the coordinate
// generator, keeps its own copy of the node grids, position and registers,
// predicts each pixel's mapped coordinate and compares every result word in
// order against it.
// ----------------------------------------------------------------------------
module warp_coord_checker #(
   parameter int GRID_COLS = wgbc_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = wgbc_pkg::GRID_ROWS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic [wgbc_pkg::OP_BITS-1:0]            req_operation,
   input  logic [wgbc_pkg::NODE_IDX_BITS-1:0]      req_node_col,
   input  logic [wgbc_pkg::NODE_IDX_BITS-1:0]      req_node_row,
   input  logic signed [wgbc_pkg::NODE_BITS-1:0]   req_node_map_x,
   input  logic signed [wgbc_pkg::NODE_BITS-1:0]   req_node_map_y,
   input  logic [wgbc_pkg::COORD_BITS-1:0]         req_pos_x,
   input  logic [wgbc_pkg::COORD_BITS-1:0]         req_pos_y,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [wgbc_pkg::OUT_BITS-1:0]    rsp_map_x,
   input  logic signed [wgbc_pkg::OUT_BITS-1:0]    rsp_map_y,
   input  logic                                    rsp_out_of_range,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [wgbc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wgbc_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output int                                      mismatch_count,
   output int                                      coords_pending,
   output int                                      coords_checked
);

   import wgbc_pkg::*;

   typedef struct packed {
      logic [OUT_BITS-1:0] map_x;
      logic [OUT_BITS-1:0] map_y;
      logic                out_of_range;
   } coord_type;

   coord_type expected_coords[$];

   logic signed [NODE_BITS-1:0] grid_x [GRID_COLS*GRID_ROWS];
   logic signed [NODE_BITS-1:0] grid_y [GRID_COLS*GRID_ROWS];
   logic [POS_BITS-1:0]         rel_col;
   logic [POS_BITS-1:0]         rel_row;
   logic [COORD_BITS-1:0]       org_x;
   logic [COORD_BITS-1:0]       org_y;
   logic [STEP_BITS-1:0]        spacing_log2;

   function automatic logic [OUT_BITS-1:0] blend4(input longint n00, n01, n10, n11,
                                                  input longint w00, w01, w10, w11,
                                                  input int unsigned s);
      longint acc;
      acc = w00 * n00 + w01 * n01 + w10 * n10 + w11 * n11;
      // arithmetic shift of a signed sum floors toward minus infinity
      return OUT_BITS'(acc >>> (2 * s));
   endfunction

   function automatic coord_type predict_coord();
      coord_type   c;
      int unsigned s;
      int          col_i, row_i, xo, yo, idx;
      longint      px0, px1, py0, py1;
      c = '0;
      c.out_of_range = 1'b1;
      s = spacing_log2;
      if (rel_col[POS_BITS-1] || rel_row[POS_BITS-1])
         return c;
      col_i = int'(rel_col);
      row_i = int'(rel_row);
      xo = col_i >> s;
      yo = row_i >> s;
      // a pixel on the last node column or row has no right or lower neighbor
      if (xo + 1 >= GRID_COLS || yo + 1 >= GRID_ROWS)
         return c;
      px1 = col_i - (xo << s);
      py1 = row_i - (yo << s);
      px0 = (longint'(1) << s) - px1;
      py0 = (longint'(1) << s) - py1;
      idx = yo * GRID_COLS + xo;
      c.map_x = blend4(grid_x[idx], grid_x[idx+1], grid_x[idx+GRID_COLS],
                       grid_x[idx+GRID_COLS+1], px0 * py0, px1 * py0, px0 * py1,
                       px1 * py1, s);
      c.map_y = blend4(grid_y[idx], grid_y[idx+1], grid_y[idx+GRID_COLS],
                       grid_y[idx+GRID_COLS+1], px0 * py0, px1 * py0, px0 * py1,
                       px1 * py1, s);
      c.out_of_range = 1'b0;
      return c;
   endfunction

   always @(posedge clock) begin : watch
      coord_type want;
      int        idx;
      if (reset) begin
         expected_coords.delete();
         rel_col        = '0;
         rel_row        = '0;
         org_x          = '0;
         org_y          = '0;
         spacing_log2   = STEP_LOG2_RESET;
         mismatch_count = 0;
         coords_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            coords_checked++;
            if (expected_coords.size() == 0) begin
               $error("result word with no pixel pending: map_x %0d map_y %0d out_of_range %0b",
                      rsp_map_x, rsp_map_y, rsp_out_of_range);
               mismatch_count++;
            end else begin
               want = expected_coords.pop_front();
               if (rsp_map_x !== want.map_x) begin
                  $error("map_x mismatch: expected %0d, got %0d",
                         $signed(want.map_x), rsp_map_x);
                  mismatch_count++;
               end
               if (rsp_map_y !== want.map_y) begin
                  $error("map_y mismatch: expected %0d, got %0d",
                         $signed(want.map_y), rsp_map_y);
                  mismatch_count++;
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  $error("out_of_range mismatch: expected %0b, got %0b",
                         want.out_of_range, rsp_out_of_range);
                  mismatch_count++;
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:  org_x = csr_wdata;
               CSR_ORIGIN_Y:  org_y = csr_wdata;
               CSR_STEP_LOG2: spacing_log2 = csr_wdata[STEP_BITS-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            case (req_operation)
               OP_WRITE_NODE: begin
                  idx = int'(req_node_row) * GRID_COLS + int'(req_node_col);
                  grid_x[idx] = req_node_map_x;
                  grid_y[idx] = req_node_map_y;
               end
               OP_START_LINE: begin
                  // position relative to the origin, wrapped to 17 bits
                  rel_col = {1'b0, req_pos_x} - {1'b0, org_x};
                  rel_row = {1'b0, req_pos_y} - {1'b0, org_y};
                  expected_coords.push_back(predict_coord());
               end
               OP_ADVANCE: begin
                  rel_col = rel_col + 1'b1;
                  expected_coords.push_back(predict_coord());
               end
               default: ;
            endcase
         end
      end
      coords_pending = expected_coords.size();
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warp grid coordinate generator testbench
// Drives node writes, line starts and pixel advances through a directed
// opening and several randomized register settings, with random idling on
// both channels and two long result stalls; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

   import wgbc_pkg::*;

   localparam int GRID_COLS        = GRID_COLS_DEF;
   localparam int GRID_ROWS        = GRID_ROWS_DEF;
   localparam int WATCHDOG_CYCLES  = 5000;
   localparam int DRAIN_CYCLES     = 16;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int PHASES           = 8;
   localparam int WORDS_PER_PHASE  = 178;

   localparam logic [OP_BITS-1:0]        OP_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [OP_BITS-1:0]          req_operation = '0;
   logic [NODE_IDX_BITS-1:0]    req_node_col = '0;
   logic [NODE_IDX_BITS-1:0]    req_node_row = '0;
   logic signed [NODE_BITS-1:0] req_node_map_x = '0;
   logic signed [NODE_BITS-1:0] req_node_map_y = '0;
   logic [COORD_BITS-1:0]       req_pos_x = '0;
   logic [COORD_BITS-1:0]       req_pos_y = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0]  rsp_map_x;
   logic signed [OUT_BITS-1:0]  rsp_map_y;
   logic                        rsp_out_of_range;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   int mismatch_count;
   int coords_pending;
   int coords_checked;

   // stimulus-side view of position and registers, used to keep every
   // in-grid pixel on nodes that have been written
   logic [POS_BITS-1:0]   trk_col = '0;
   logic [POS_BITS-1:0]   trk_row = '0;
   logic [COORD_BITS-1:0] trk_org_x = '0;
   logic [COORD_BITS-1:0] trk_org_y = '0;
   logic [STEP_BITS-1:0]  trk_step = STEP_LOG2_RESET;
   bit                    node_written [GRID_COLS*GRID_ROWS];

   bit sender_no_gaps     = 1'b0;
   bit receiver_no_stalls = 1'b0;
   bit hold_off_req       = 1'b0;

   int words_sent       = 0;
   int node_writes      = 0;
   int pixels           = 0;
   int pixels_outside   = 0;
   int settings_applied = 0;
   int stuck_cycles     = 0;
   int step_plan [PHASES] = '{0, 7, 6, 1, 2, 3, 5, 4};

   warp_grid_bilinear_coordinate_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_node_col     (req_node_col),
      .req_node_row     (req_node_row),
      .req_node_map_x   (req_node_map_x),
      .req_node_map_y   (req_node_map_y),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_map_x        (rsp_map_x),
      .rsp_map_y        (rsp_map_y),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   warp_coord_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_node_col     (req_node_col),
      .req_node_row     (req_node_row),
      .req_node_map_x   (req_node_map_x),
      .req_node_map_y   (req_node_map_y),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_map_x        (rsp_map_x),
      .rsp_map_y        (rsp_map_y),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .coords_pending   (coords_pending),
      .coords_checked   (coords_checked)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // result side: random stalls, plus one long hold-off whenever requested
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!receiver_no_stalls && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60)
                                                     : $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (sender_no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [NODE_BITS-1:0] rand_node();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return '0;
         3: return '1;
         4, 5, 6: return NODE_BITS'(int'($urandom_range(0, 2097151)) - 1048576);
         default: return NODE_BITS'($urandom);
      endcase
   endfunction

   function automatic bit in_grid(input logic [POS_BITS-1:0] col, row);
      if (col[POS_BITS-1] || row[POS_BITS-1])
         return 1'b0;
      return ((int'(col) >> trk_step) + 1 < GRID_COLS) &&
             ((int'(row) >> trk_step) + 1 < GRID_ROWS);
   endfunction

   task automatic send_word(input logic [OP_BITS-1:0] op,
                            input logic [NODE_IDX_BITS-1:0] col, row,
                            input logic signed [NODE_BITS-1:0] mx, my,
                            input logic [COORD_BITS-1:0] px, py);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_node_col   <= col;
      req_node_row   <= row;
      req_node_map_x <= mx;
      req_node_map_y <= my;
      req_pos_x      <= px;
      req_pos_y      <= py;
      do @(posedge clock); while (!req_ready);
      if (op != OP_UNUSED)
         words_sent++;
   endtask

   task automatic write_node(input logic [NODE_IDX_BITS-1:0] col, row,
                             input logic signed [NODE_BITS-1:0] mx, my);
      send_word(OP_WRITE_NODE, col, row, mx, my, COORD_BITS'($urandom),
                COORD_BITS'($urandom));
      node_written[int'(row) * GRID_COLS + int'(col)] = 1'b1;
      node_writes++;
   endtask

   // fill in any of the four corner nodes of the current cell not yet written, then send the pixel
   task automatic issue_pixel(input logic [OP_BITS-1:0] op,
                              input logic [COORD_BITS-1:0] px, py);
      int xo, yo;
      if (in_grid(trk_col, trk_row)) begin
         xo = int'(trk_col) >> trk_step;
         yo = int'(trk_row) >> trk_step;
         for (int dy = 0; dy < 2; dy++)
            for (int dx = 0; dx < 2; dx++)
               if (!node_written[(yo + dy) * GRID_COLS + xo + dx])
                  write_node(NODE_IDX_BITS'(xo + dx), NODE_IDX_BITS'(yo + dy),
                             rand_node(), rand_node());
      end else begin
         pixels_outside++;
      end
      send_word(op, NODE_IDX_BITS'($urandom), NODE_IDX_BITS'($urandom), rand_node(),
                rand_node(), px, py);
      pixels++;
   endtask

   task automatic start_line(input logic [COORD_BITS-1:0] px, py);
      trk_col = {1'b0, px} - {1'b0, trk_org_x};
      trk_row = {1'b0, py} - {1'b0, trk_org_y};
      issue_pixel(OP_START_LINE, px, py);
   endtask

   task automatic advance_pixel();
      trk_col = trk_col + 1'b1;
      issue_pixel(OP_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom));
   endtask

   // drop valid and let every outstanding pixel come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (coords_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_register(input logic [CSR_INDEX_BITS-1:0] idx,
                               input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ORIGIN_X:  trk_org_x = data;
         CSR_ORIGIN_Y:  trk_org_y = data;
         CSR_STEP_LOG2: trk_step = data[STEP_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [COORD_BITS-1:0] ox, oy,
                                input logic [STEP_BITS-1:0] st);
      wait_idle();
      set_register(CSR_ORIGIN_X, ox);
      set_register(CSR_ORIGIN_Y, oy);
      // upper data bits are don't-care for the spacing register
      set_register(CSR_STEP_LOG2, {(CSR_DATA_BITS - STEP_BITS)'($urandom), st});
      settings_applied++;
   endtask

   task automatic run_phase(input int n_words);
      int first_word, r, off_x, off_y;
      first_word = words_sent;
      while (words_sent - first_word < n_words) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            write_node(NODE_IDX_BITS'($urandom), NODE_IDX_BITS'($urandom), rand_node(),
                       rand_node());
         end else if (r < 16) begin
            send_word(OP_UNUSED, NODE_IDX_BITS'($urandom), NODE_IDX_BITS'($urandom),
                      rand_node(), rand_node(), COORD_BITS'($urandom),
                      COORD_BITS'($urandom));
         end else if (r < 36) begin
            if ($urandom_range(0, 9) < 8) begin
               off_x = $urandom_range(0, (63 << trk_step) - 1);
               off_y = $urandom_range(0, (63 << trk_step) - 1);
               start_line(COORD_BITS'(trk_org_x + off_x), COORD_BITS'(trk_org_y + off_y));
            end else begin
               start_line(COORD_BITS'($urandom), COORD_BITS'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 24)) advance_pixel();
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner cell with extreme node values
      write_node(6'd0, 6'd0, 32'sh7FFFFFFF, 32'sh80000000);
      write_node(6'd1, 6'd0, 32'sh80000000, 32'sh7FFFFFFF);
      write_node(6'd0, 6'd1, 32'sh00000000, 32'shFFFFFFFF);
      write_node(6'd1, 6'd1, 32'shFFFFFFFF, 32'sh00000000);
      advance_pixel();
      start_line(16'd0, 16'd0);
      advance_pixel();
      advance_pixel();
      start_line(16'd15, 16'd15);
      // last cell of the grid, then the last node column and row
      write_node(6'd63, 6'd63, 32'sh7FFFFFFF, 32'sh80000000);
      start_line(16'd1007, 16'd1007);
      advance_pixel();
      start_line(16'd15, 16'd1008);
      // far corner, then wrap the column past the top of the range
      start_line(16'hFFFF, 16'hFFFF);
      advance_pixel();
      send_word(OP_UNUSED, 6'h3F, 6'h3F, '1, '1, 16'hFFFF, 16'hFFFF);
      wait_idle();
      set_register(CSR_UNUSED, 16'hFFFF);
      set_register(CSR_ORIGIN_X, 16'd100);
      start_line(16'd50, 16'd5);
      start_line(16'd100, 16'd5);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: apply_setting(16'd0, 16'd0, STEP_BITS'(step_plan[ph]));
            1: apply_setting(16'hFFFF, 16'hFFFF, STEP_BITS'(step_plan[ph]));
            default: apply_setting(COORD_BITS'($urandom_range(0, 40000)),
                                   COORD_BITS'($urandom_range(0, 40000)),
                                   STEP_BITS'(step_plan[ph]));
         endcase
         sender_no_gaps     = (ph == 2 || ph == 5);
         receiver_no_stalls = (ph == 5 || ph == 6);
         if (ph == 2 || ph == 7)
            hold_off_req = 1'b1;
         run_phase(WORDS_PER_PHASE);
      end

      wait_idle();
      $display("Sent %0d words: %0d node writes, %0d pixels (%0d outside the grid), %0d settings.",
               words_sent, node_writes, pixels, pixels_outside, settings_applied);
      $display("Compared %0d coordinate words, %0d mismatches.", coords_checked,
               mismatch_count);
      if (mismatch_count == 0 && coords_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/wgbc_pkg.sv
design/wgbc_node_ram.sv
design/wgbc_blend.sv
design/warp_grid_bilinear_coordinate_generator.sv
verif/warp_coord_checker.sv
verif/tb_top.sv
